[hw/rtl/dls_pkg.sv]
// ============================================================================
// dls_pkg : shared definitions for the delta list sleep queue
// Field widths, operation and status codes, cell commands.
// ============================================================================
package dls_pkg;

    localparam int MAX_TASKS_DEF   = 16;
    localparam int DELAY_WIDTH_DEF = 16;

    localparam int ID_W       = 4;
    localparam int NUM_IDS    = 16;
    localparam int KIND_W     = 2;
    localparam int DELAY_IN_W = 16;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 8;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_WAITING   = 2'd3;

    typedef enum logic [2:0] {
        CMD_HOLD      = 3'd0,
        CMD_NEW       = 3'd1,
        CMD_LEFT      = 3'd2,
        CMD_LEFT_SUB  = 3'd3,
        CMD_RIGHT     = 3'd4,
        CMD_RIGHT_ADD = 3'd5,
        CMD_DEC       = 3'd6
    } t_cell_cmd;

endpackage

[hw/rtl/delta_list_sleep_queue.sv]
// ============================================================================
// delta_list_sleep_queue : sleep queue of task slots kept as a delta list
// Input words carry add, remove or tick; output words carry status and
// released tasks.
//
// The list lives in a row of MAX_TASKS cells, head in cell 0, each cell
// holding a slot and its delay relative to the cell on its left. Inserts
// shift the tail right by one cell, unlinks and releases shift it left.
// The sequencer walks the row one cell per cycle to find a position.
//
// One input word is worked on at a time; s_tready is high while idle.
// Add and remove walk the row from the head, p cells (up to MAX_TASKS - 1),
// before their output word; errors and zero delay give their word without a walk.
// Tick gives one word, then one word per cycle for each further released
// task while m_tready does not stall it; the last word of a tick has m_tlast
// set. Kind 3 gives no word.
// A single output register parts the sides; when m_tready is low the word
// holds and the sequencer waits. Reset clears the list and output valid;
// the block is ready as soon as reset is released.
// ============================================================================
module delta_list_sleep_queue #(
    parameter int MAX_TASKS   = dls_pkg::MAX_TASKS_DEF,
    parameter int DELAY_WIDTH = dls_pkg::DELAY_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dls_pkg::S_DATA_W-1:0]    s_tdata,   // task_id[3:0], delay_ticks[19:4], zero
    input  logic [dls_pkg::KIND_W-1:0]      s_tuser,   // kind[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dls_pkg::M_DATA_W-1:0]    m_tdata,   // status[1:0], released[2],
                                                       // released_task[6:3], reschedule[7]
    output logic                            m_tlast
);

    logic [MAX_TASKS-1:0]                      cell_valid;
    logic [MAX_TASKS-1:0][dls_pkg::ID_W-1:0]   cell_id;
    logic [MAX_TASKS-1:0][DELAY_WIDTH-1:0]     cell_delta;
    dls_pkg::t_cell_cmd [MAX_TASKS-1:0]        cmd;
    logic [dls_pkg::ID_W-1:0]                  new_id;
    logic [DELAY_WIDTH-1:0]                    new_delta;
    logic [dls_pkg::STATUS_W-1:0]              out_status;
    logic                                      out_rel;
    logic [dls_pkg::ID_W-1:0]                  out_task;
    logic                                      out_resched;

    dls_ctrl #(
        .MAX_TASKS   (MAX_TASKS),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_tvalid),
        .o_in_ready     (s_tready),
        .i_in_kind      (s_tuser),
        .i_in_id        (s_tdata[3:0]),
        .i_in_delay     (s_tdata[19:4]),
        .o_out_valid    (m_tvalid),
        .i_out_ready    (m_tready),
        .o_out_status   (out_status),
        .o_out_released (out_rel),
        .o_out_task     (out_task),
        .o_out_resched  (out_resched),
        .o_out_last     (m_tlast),
        .i_cell_valid   (cell_valid),
        .i_cell_id      (cell_id),
        .i_cell_delta   (cell_delta),
        .o_cmd          (cmd),
        .o_new_id       (new_id),
        .o_new_delta    (new_delta)
    );

    assign m_tdata = {out_resched, out_task, out_rel, out_status};

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        logic                     left_valid, right_valid;
        logic [dls_pkg::ID_W-1:0] left_id, right_id;
        logic [DELAY_WIDTH-1:0]   left_delta, right_delta;

        if (g == 0) begin : g_first
            assign left_valid = 1'b0;
            assign left_id    = '0;
            assign left_delta = '0;
        end else begin : g_mid_l
            assign left_valid = cell_valid[g-1];
            assign left_id    = cell_id[g-1];
            assign left_delta = cell_delta[g-1];
        end

        if (g == MAX_TASKS - 1) begin : g_last
            assign right_valid = 1'b0;
            assign right_id    = '0;
            assign right_delta = '0;
        end else begin : g_mid_r
            assign right_valid = cell_valid[g+1];
            assign right_id    = cell_id[g+1];
            assign right_delta = cell_delta[g+1];
        end

        dls_cell #(
            .DELAY_WIDTH (DELAY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd[g]),
            .i_new_id      (new_id),
            .i_new_delta   (new_delta),
            .i_left_valid  (left_valid),
            .i_left_id     (left_id),
            .i_left_delta  (left_delta),
            .i_right_valid (right_valid),
            .i_right_id    (right_id),
            .i_right_delta (right_delta),
            .o_valid       (cell_valid[g]),
            .o_id          (cell_id[g]),
            .o_delta       (cell_delta[g])
        );
    end

endmodule

[hw/rtl/dls_cell.sv]
// ============================================================================
// dls_cell : one entry of the delta list
// Holds a task slot and its delay relative to the cell on its left.
// ============================================================================
module dls_cell #(
    parameter int DELAY_WIDTH = dls_pkg::DELAY_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dls_pkg::t_cell_cmd        i_cmd,
    input  logic [dls_pkg::ID_W-1:0]  i_new_id,
    input  logic [DELAY_WIDTH-1:0]    i_new_delta,
    input  logic                      i_left_valid,
    input  logic [dls_pkg::ID_W-1:0]  i_left_id,
    input  logic [DELAY_WIDTH-1:0]    i_left_delta,
    input  logic                      i_right_valid,
    input  logic [dls_pkg::ID_W-1:0]  i_right_id,
    input  logic [DELAY_WIDTH-1:0]    i_right_delta,
    output logic                      o_valid,
    output logic [dls_pkg::ID_W-1:0]  o_id,
    output logic [DELAY_WIDTH-1:0]    o_delta
);

    logic                     r_valid, n_valid;
    logic [dls_pkg::ID_W-1:0] r_id, n_id;
    logic [DELAY_WIDTH-1:0]   r_delta, n_delta;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_delta = r_delta;
        case (i_cmd)
            dls_pkg::CMD_NEW: begin
                n_valid = 1'b1;
                n_id    = i_new_id;
                n_delta = i_new_delta;
            end
            dls_pkg::CMD_LEFT: begin
                n_valid = i_left_valid;
                n_id    = i_left_id;
                n_delta = i_left_delta;
            end
            dls_pkg::CMD_LEFT_SUB: begin
                n_valid = i_left_valid;
                n_id    = i_left_id;
                n_delta = i_left_delta - i_new_delta;
            end
            dls_pkg::CMD_RIGHT: begin
                n_valid = i_right_valid;
                n_id    = i_right_id;
                n_delta = i_right_delta;
            end
            dls_pkg::CMD_RIGHT_ADD: begin
                n_valid = i_right_valid;
                n_id    = i_right_id;
                n_delta = i_right_delta + r_delta;
            end
            dls_pkg::CMD_DEC: begin
                n_delta = r_delta - DELAY_WIDTH'(1);
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_id    <= n_id;
        r_delta <= n_delta;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_delta = r_delta;

endmodule

[hw/rtl/dls_ctrl.sv]
// ============================================================================
// dls_ctrl : sequencer of the delta list
// Walks the cell row for add and remove, releases expired heads on a tick,
// and holds the output word register.
// ============================================================================
module dls_ctrl #(
    parameter int MAX_TASKS   = dls_pkg::MAX_TASKS_DEF,
    parameter int DELAY_WIDTH = dls_pkg::DELAY_WIDTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic [dls_pkg::KIND_W-1:0]                 i_in_kind,
    input  logic [dls_pkg::ID_W-1:0]                   i_in_id,
    input  logic [dls_pkg::DELAY_IN_W-1:0]             i_in_delay,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic [dls_pkg::STATUS_W-1:0]               o_out_status,
    output logic                                       o_out_released,
    output logic [dls_pkg::ID_W-1:0]                   o_out_task,
    output logic                                       o_out_resched,
    output logic                                       o_out_last,
    input  logic [MAX_TASKS-1:0]                       i_cell_valid,
    input  logic [MAX_TASKS-1:0][dls_pkg::ID_W-1:0]    i_cell_id,
    input  logic [MAX_TASKS-1:0][DELAY_WIDTH-1:0]      i_cell_delta,
    output dls_pkg::t_cell_cmd [MAX_TASKS-1:0]         o_cmd,
    output logic [dls_pkg::ID_W-1:0]                   o_new_id,
    output logic [DELAY_WIDTH-1:0]                     o_new_delta
);

    localparam int KW = $clog2(MAX_TASKS);
    localparam int EW = DELAY_WIDTH + dls_pkg::DELAY_IN_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_REM  = 5'b00100,
        S_TICK = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state                        r_state, n_state;
    logic [KW-1:0]                 r_k, n_k;
    logic [DELAY_WIDTH-1:0]        r_tm, n_tm;
    logic [dls_pkg::ID_W-1:0]      r_t, n_t;
    logic [dls_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [dls_pkg::NUM_IDS-1:0]   r_wait, n_wait;

    logic                          r_out_valid, n_out_valid;
    logic [dls_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic                          r_out_rel, n_out_rel;
    logic [dls_pkg::ID_W-1:0]      r_out_task, n_out_task;
    logic                          r_out_resched, n_out_resched;
    logic                          r_out_last, n_out_last;

    logic                          accept, out_free;
    logic [EW-1:0]                 dly_ext;
    logic [DELAY_WIDTH-1:0]        dly_sat;
    logic                          in_range;
    logic                          cur_valid;
    logic [dls_pkg::ID_W-1:0]      cur_id;
    logic [DELAY_WIDTH-1:0]        cur_delta;
    logic                          cur_after;
    logic                          head_expired, next_expired;
    logic                          do_insert, do_unlink, do_dec, do_shift;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    assign dly_ext  = EW'(i_in_delay);
    assign dly_sat  = (dly_ext > EW'({DELAY_WIDTH{1'b1}})) ? '1 : dly_ext[DELAY_WIDTH-1:0];
    assign in_range = int'(i_in_id) < MAX_TASKS;

    assign cur_valid = i_cell_valid[r_k];
    assign cur_id    = i_cell_id[r_k];
    assign cur_delta = i_cell_delta[r_k];
    // new slot goes ahead of the current cell
    assign cur_after = !cur_valid || (cur_delta > r_tm) || (cur_delta == r_tm && cur_id > r_t);

    assign head_expired = i_cell_valid[0] && (i_cell_delta[0] == '0);
    assign next_expired = i_cell_valid[1] && (i_cell_delta[1] == '0);

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_tm          = r_tm;
        n_t           = r_t;
        n_status      = r_status;
        n_wait        = r_wait;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_rel     = r_out_rel;
        n_out_task    = r_out_task;
        n_out_resched = r_out_resched;
        n_out_last    = r_out_last;
        do_insert     = 1'b0;
        do_unlink     = 1'b0;
        do_dec        = 1'b0;
        do_shift      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_k  = '0;
                    n_t  = i_in_id;
                    n_tm = dly_sat;
                    case (i_in_kind)
                        dls_pkg::KIND_ADD: begin
                            n_state = S_RESP;
                            if (i_in_delay == '0) begin
                                n_status = dls_pkg::ST_ZERO;
                            end else if (!in_range) begin
                                n_status = dls_pkg::ST_NOT_FOUND;
                            end else if (r_wait[i_in_id]) begin
                                n_status = dls_pkg::ST_WAITING;
                            end else begin
                                n_state = S_ADD;
                            end
                        end
                        dls_pkg::KIND_REMOVE: begin
                            if (!in_range || !r_wait[i_in_id]) begin
                                n_status = dls_pkg::ST_NOT_FOUND;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_REM;
                            end
                        end
                        dls_pkg::KIND_TICK: begin
                            if (i_cell_valid[0]) begin
                                do_dec  = 1'b1;
                                n_state = S_TICK;
                            end else begin
                                n_status = dls_pkg::ST_DONE;
                                n_state  = S_RESP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (cur_after) begin
                    do_insert   = 1'b1;
                    n_wait[r_t] = 1'b1;
                    n_status    = dls_pkg::ST_DONE;
                    n_state     = S_RESP;
                end else begin
                    n_tm = r_tm - cur_delta;
                    n_k  = r_k + KW'(1);
                end
            end
            S_REM: begin
                if (cur_valid && cur_id == r_t) begin
                    do_unlink   = 1'b1;
                    n_wait[r_t] = 1'b0;
                    n_status    = dls_pkg::ST_DONE;
                    n_state     = S_RESP;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_TICK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = dls_pkg::ST_DONE;
                    if (head_expired) begin
                        do_shift             = 1'b1;
                        n_wait[i_cell_id[0]] = 1'b0;
                        n_out_rel            = 1'b1;
                        n_out_task           = i_cell_id[0];
                        n_out_resched        = !next_expired;
                        n_out_last           = !next_expired;
                        if (!next_expired) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_out_rel     = 1'b0;
                        n_out_task    = '0;
                        n_out_resched = 1'b0;
                        n_out_last    = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_rel     = 1'b0;
                    n_out_task    = '0;
                    n_out_resched = 1'b0;
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            o_cmd[i] = dls_pkg::CMD_HOLD;
            if (do_shift) begin
                o_cmd[i] = dls_pkg::CMD_RIGHT;
            end
            if (do_dec && i == 0) begin
                o_cmd[i] = dls_pkg::CMD_DEC;
            end
            if (do_insert) begin
                if (KW'(i) == r_k) begin
                    o_cmd[i] = dls_pkg::CMD_NEW;
                end else if (i > 0 && KW'(i - 1) == r_k) begin
                    o_cmd[i] = dls_pkg::CMD_LEFT_SUB;
                end else if (KW'(i) > r_k) begin
                    o_cmd[i] = dls_pkg::CMD_LEFT;
                end
            end
            if (do_unlink) begin
                if (KW'(i) == r_k) begin
                    o_cmd[i] = dls_pkg::CMD_RIGHT_ADD;
                end else if (KW'(i) > r_k) begin
                    o_cmd[i] = dls_pkg::CMD_RIGHT;
                end
            end
        end
    end

    assign o_new_id    = r_t;
    assign o_new_delta = r_tm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
        r_k           <= n_k;
        r_tm          <= n_tm;
        r_t           <= n_t;
        r_status      <= n_status;
        r_out_status  <= n_out_status;
        r_out_rel     <= n_out_rel;
        r_out_task    <= n_out_task;
        r_out_resched <= n_out_resched;
        r_out_last    <= n_out_last;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_out_status   = r_out_status;
    assign o_out_released = r_out_rel;
    assign o_out_task     = r_out_task;
    assign o_out_resched  = r_out_resched;
    assign o_out_last     = r_out_last;

endmodule

[hw/rtl/dls_checker.sv]
// ============================================================================
// dls_checker : port level checks of the delta list sleep queue
// Output word stability, input busy after an accepted word, and consistency of the result flags.
// ============================================================================
module dls_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dls_pkg::KIND_W-1:0]      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dls_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            m_tlast
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // block is busy after a word that yields a result
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && (s_tuser == dls_pkg::KIND_ADD ||
        s_tuser == dls_pkg::KIND_REMOVE || s_tuser == dls_pkg::KIND_TICK) |=> !s_tready)
        else $error("input accepted while previous word in progress");

    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[2] |-> m_tlast)
        else $error("non release word without last");

    a_resched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[7] |-> m_tlast && m_tdata[2])
        else $error("reschedule outside last release");

    a_status_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[1:0] != dls_pkg::ST_DONE |-> !m_tdata[2] && !m_tdata[7])
        else $error("error status with release");

endmodule

bind delta_list_sleep_queue dls_checker u_dls_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/delta_list_sleep_queue_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// delta_list_sleep_queue_tb : self-checking bench for the sleep queue
// A mirror of the delta list predicts every output word for each accepted
// input word. Directed words hit the corner cases first, then random add,
// remove and tick traffic runs with bursty input and a stalling output side.
// ============================================================================
module delta_list_sleep_queue_tb;

    localparam int  NTASK     = 16;
    localparam logic [4:0] NIL = 5'd16;
    localparam int  N_RANDOM  = 88;
    localparam int  DRAIN_CYC = 2 * NTASK + 8;
    localparam int  LIMIT     = 200000;

    typedef struct packed {
        logic [dls_pkg::STATUS_W-1:0] status;
        logic                         released;
        logic [dls_pkg::ID_W-1:0]     rel_task;
        logic                         resched;
        logic                         is_last;
    } t_due_word;

    class sleep_list_mirror;
        logic [4:0]  head;
        logic [4:0]  succ[NTASK];
        logic [15:0] delta[NTASK];
        bit          queued[NTASK];
        t_due_word   due_words[$];
        int          errors;

        function new();
            head = NIL;
            for (int i = 0; i < NTASK; i++) begin
                succ[i]   = NIL;
                delta[i]  = '0;
                queued[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void note_word(logic [dls_pkg::KIND_W-1:0] kind,
                                logic [dls_pkg::ID_W-1:0] t,
                                logic [15:0] dly);
            logic [4:0]                   prev;
            logic [4:0]                   cur;
            logic [4:0]                   nx;
            logic [15:0]                  rem;
            logic [dls_pkg::ID_W-1:0]     rel[NTASK];
            logic [dls_pkg::STATUS_W-1:0] st;
            int                           n;
            bit                           stop;
            prev = NIL;
            cur  = head;
            stop = 1'b0;
            n    = 0;
            case (kind)
                dls_pkg::KIND_ADD: begin
                    if (dly == 16'd0) begin
                        st = dls_pkg::ST_ZERO;
                    end else if (queued[t]) begin
                        st = dls_pkg::ST_WAITING;
                    end else begin
                        rem = dly;
                        for (int g = 0; g < NTASK && cur != NIL && !stop; g++) begin
                            if (delta[cur] > rem || (delta[cur] == rem && cur[3:0] > t)) begin
                                stop = 1'b1;
                            end else begin
                                rem  = rem - delta[cur];
                                prev = cur;
                                cur  = succ[cur];
                            end
                        end
                        delta[t] = rem;
                        succ[t]  = cur;
                        if (cur != NIL) delta[cur] = delta[cur] - rem;
                        if (prev != NIL) succ[prev] = {1'b0, t};
                        else head = {1'b0, t};
                        queued[t] = 1'b1;
                        st = dls_pkg::ST_DONE;
                    end
                    due_words.push_back('{st, 1'b0, 4'd0, 1'b0, 1'b1});
                end
                dls_pkg::KIND_REMOVE: begin
                    if (!queued[t]) begin
                        st = dls_pkg::ST_NOT_FOUND;
                    end else begin
                        for (int g = 0; g < NTASK && cur != NIL && !stop; g++) begin
                            if (cur[3:0] == t) begin
                                stop = 1'b1;
                            end else begin
                                prev = cur;
                                cur  = succ[cur];
                            end
                        end
                        nx = succ[t];
                        if (nx != NIL) delta[nx] = delta[nx] + delta[t];
                        if (prev != NIL) succ[prev] = nx;
                        else head = nx;
                        succ[t]   = NIL;
                        queued[t] = 1'b0;
                        st = dls_pkg::ST_DONE;
                    end
                    due_words.push_back('{st, 1'b0, 4'd0, 1'b0, 1'b1});
                end
                dls_pkg::KIND_TICK: begin
                    if (head != NIL) begin
                        delta[head] = delta[head] - 16'd1;
                        while (head != NIL && delta[head] == 16'd0 && n < NTASK) begin
                            cur          = head;
                            head         = succ[cur];
                            succ[cur]    = NIL;
                            queued[cur]  = 1'b0;
                            rel[n]       = cur[3:0];
                            n++;
                        end
                    end
                    if (n == 0) begin
                        due_words.push_back('{dls_pkg::ST_DONE, 1'b0, 4'd0, 1'b0, 1'b1});
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            due_words.push_back('{dls_pkg::ST_DONE, 1'b1, rel[i],
                                                  i == n - 1, i == n - 1});
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [dls_pkg::M_DATA_W-1:0] data, logic tl);
            t_due_word want;
            t_due_word got;
            got = '{data[1:0], data[2], data[6:3], data[7], tl};
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output word: %h last %b", data, tl);
            end else begin
                want = due_words.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp st %0d rel %b task %0d rs %b last %b",
                                 want.status, want.released, want.rel_task,
                                 want.resched, want.is_last);
                        $display("          got st %0d rel %b task %0d rs %b last %b",
                                 got.status, got.released, got.rel_task,
                                 got.resched, got.is_last);
                    end
                end
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [dls_pkg::S_DATA_W-1:0]   s_tdata;
    logic [dls_pkg::KIND_W-1:0]     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dls_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           m_tlast;

    sleep_list_mirror sb;
    int               cycles = 0;
    int               burst_left;
    int               rx_cnt = 0;

    delta_list_sleep_queue u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern: four modes of m_tready, chosen from rx_cnt
    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 1;
        case ((rx_cnt / 64) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cnt % 4 == 0);
            default: m_tready <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata[3:0], s_tdata[19:4]);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast);
        end
    end

    task automatic send_word(logic [dls_pkg::KIND_W-1:0] kind, logic [dls_pkg::ID_W-1:0] t,
                             logic [15:0] dly);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, dly, t};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        int pick;
        sb         = new();
        burst_left = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= dls_pkg::KIND_ADD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases
        send_word(dls_pkg::KIND_TICK,   4'd0,  16'h0000);  // empty list
        send_word(dls_pkg::KIND_ADD,    4'd3,  16'h0000);  // zero delay
        send_word(dls_pkg::KIND_REMOVE, 4'd3,  16'h0000);  // not waiting
        send_word(dls_pkg::KIND_ADD,    4'd15, 16'hFFFF);
        send_word(dls_pkg::KIND_ADD,    4'd0,  16'h0001);
        send_word(dls_pkg::KIND_ADD,    4'd0,  16'h0005);  // already waiting
        send_word(dls_pkg::KIND_ADD,    4'd0,  16'h0000);  // zero beats waiting
        send_word(dls_pkg::KIND_ADD,    4'd5,  16'h0002);
        send_word(dls_pkg::KIND_ADD,    4'd4,  16'h0002);  // tie, lower id first
        send_word(dls_pkg::KIND_ADD,    4'd6,  16'h0002);
        send_word(dls_pkg::KIND_ADD,    4'd10, 16'hAAAA);
        send_word(dls_pkg::KIND_ADD,    4'd9,  16'h5555);
        send_word(dls_pkg::KIND_TICK,   4'd7,  16'h1234);
        send_word(dls_pkg::KIND_REMOVE, 4'd5,  16'h0000);
        send_word(dls_pkg::KIND_TICK,   4'd0,  16'h0000);  // two released
        send_word(dls_pkg::KIND_REMOVE, 4'd10, 16'h0000);
        send_word(dls_pkg::KIND_REMOVE, 4'd15, 16'h0000);
        send_word(dls_pkg::KIND_TICK,   4'd0,  16'h0000);  // not expiring
        send_word(dls_pkg::KIND_REMOVE, 4'd9,  16'h0000);
        send_word(dls_pkg::KIND_REMOVE, 4'd9,  16'h0000);
        send_word(2'd3,                 4'd7,  16'h1234);  // unused kind
        send_word(dls_pkg::KIND_ADD,    4'd7,  16'h0003);
        send_word(dls_pkg::KIND_TICK,   4'd0,  16'h0000);
        wait_drained();

        // random traffic; first round sends an add for every task id, then ticks to release them
        sent = 0;
        while (sent < N_RANDOM) begin
            pick = (sent == 0) ? 0 : $urandom_range(0, 99);
            if (pick < 6) begin
                for (int i = 0; i < NTASK; i++)
                    send_word(dls_pkg::KIND_ADD, i[3:0],
                              (sent == 0) ? 16'd1 : 16'($urandom_range(1, 3)));
                repeat (3) send_word(dls_pkg::KIND_TICK, 4'($urandom_range(0, 15)),
                                     16'($urandom));
                sent += NTASK + 3;
            end else if (pick < 40) begin
                send_word(dls_pkg::KIND_ADD, 4'($urandom_range(0, 15)),
                          16'($urandom_range(1, 6)));
                sent++;
            end else if (pick < 45) begin
                send_word(dls_pkg::KIND_ADD, 4'($urandom_range(0, 15)), 16'($urandom));
                sent++;
            end else if (pick < 48) begin
                send_word(dls_pkg::KIND_ADD, 4'($urandom_range(0, 15)), 16'd0);
                sent++;
            end else if (pick < 63) begin
                send_word(dls_pkg::KIND_REMOVE, 4'($urandom_range(0, 15)), 16'($urandom));
                sent++;
            end else if (pick < 98) begin
                send_word(dls_pkg::KIND_TICK, 4'($urandom_range(0, 15)), 16'($urandom));
                sent++;
            end else begin
                send_word(2'd3, 4'($urandom_range(0, 15)), 16'($urandom));
            end
            if (sent > 0 && sent % 50 == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
